>>> rtl/pnp_pkg.sv
`default_nettype none
package pnp_pkg;

  localparam int unsigned IdBitsDef    = 16;
  localparam int unsigned ScrFracDef   = 4;
  localparam int unsigned ClipW        = 51;
  localparam int unsigned NumW         = 52;
  localparam int unsigned QuoW         = 17;
  localparam int unsigned ProdW        = 66;
  localparam int unsigned OpW          = 33;
  localparam int unsigned WEpsUnits    = 26843;
  localparam int unsigned DepthOne     = 16384;

  localparam logic [2:0] RegRowX   = 3'd0;
  localparam logic [2:0] RegRowY   = 3'd1;
  localparam logic [2:0] RegRowZ   = 3'd2;
  localparam logic [2:0] RegRowW   = 3'd3;
  localparam logic [2:0] RegVpMin  = 3'd4;
  localparam logic [2:0] RegVpMax  = 3'd5;
  localparam logic [2:0] RegCursor = 3'd6;
  localparam logic [2:0] RegRadius = 3'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        object_id;
    logic               frame_start;
  } pnp_in_t;

  typedef struct packed {
    logic               visible;
    logic [15:0]        screen_x;
    logic [15:0]        screen_y;
    logic signed [15:0] depth;
    logic               hover_valid;
    logic [15:0]        hover_id;
    logic [15:0]        hover_x;
    logic [15:0]        hover_y;
  } pnp_out_t;

endpackage
`default_nettype wire

>>> rtl/pnp_mul.sv
`default_nettype none
module pnp_mul
  import pnp_pkg::*;
(
  input  wire                     clk_i,
  input  wire signed [OpW-1:0]    a_i,
  input  wire signed [OpW-1:0]    b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/pnp_div.sv
`default_nettype none
module pnp_div
  import pnp_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [NumW+QuoW-1:0]     num_i,
  input  wire  [NumW-1:0]          den_i,
  output logic                     done_o,
  output logic [QuoW-1:0]          quo_o,
  output logic [NumW-1:0]          rem_o
);

  // The caller guarantees num_i >> QuoW < den_i, so the quotient fits QuoW bits.
  logic [NumW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  low_q, low_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [NumW-1:0]  den_q;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NumW:0]    trial;
  logic [NumW:0]    diff;

  always_comb begin
    trial  = {rem_q, low_q[QuoW-1]};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i[NumW+QuoW-1:QuoW];
      low_d  = num_i[QuoW-1:0];
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      low_d = {low_q[QuoW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[NumW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[NumW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule
`default_nettype wire

>>> rtl/project_and_pick_nearest_point_core.sv
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o  in_data_i  (pnp_in_t)
// out      output     out_valid_o/out_stall_i out_data_o (pnp_out_t)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// A rejected point goes from the tests straight to the hand-over, a visible one through
// three divisions and the distance test first. The sixteen products run on the one
// shared multiplier, then the tests; each division takes two partial products, a start
// state and the seventeen steps of the shared divider. The distance test and the
// hand-over follow, and the block passes through its idle state before the next
// transfer. Reset clears the control state and the search; the configuration registers
// take their defaults. A stalled result sits in the output register while the next point
// is already being worked on; the block waits only to hand over that result.
module project_and_pick_nearest_point_core
  import pnp_pkg::*;
#(
  parameter int unsigned ID_BITS          = IdBitsDef,
  parameter int unsigned SCREEN_FRAC_BITS = ScrFracDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  pnp_in_t     in_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output pnp_out_t    out_data_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [63:0] cfg_data_i
);

  localparam int unsigned RadW  = 8 + SCREEN_FRAC_BITS;
  localparam int unsigned DistW = 34;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_TEST, S_MLO, S_MHI, S_MWAIT, S_DWAIT,
    S_SQX, S_SQY, S_SQR, S_CMP, S_DONE
  } state_e;

  state_e state_q;

  logic [63:0] mat_q [4];
  logic [31:0] vp_min_q, vp_max_q, cursor_q;
  logic [7:0]  radius_q;

  pnp_in_t                  item_q;
  logic signed [ClipW-1:0]  clip_q [4];
  logic [4:0]               cnt_q;
  logic [1:0]               job_q;
  logic                     vis_q;
  logic [47:0]              plo_q;
  logic [QuoW-1:0]          qres_q [3];
  logic [32:0]              dx2_q, dy2_q;

  logic                     found_q;
  logic [DistW-1:0]         best_dist_q;
  logic [ID_BITS-1:0]       best_obj_q;
  logic [15:0]              best_x_q, best_y_q;

  pnp_out_t out_q;
  logic     out_valid_q;

  // Shared multiplier.
  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  pnp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Shared divider.
  logic                    div_start;
  logic                    div_done;
  logic [NumW+QuoW-1:0]    div_num;
  logic [NumW-1:0]         div_den;
  logic [QuoW-1:0]         div_quo;
  logic [NumW-1:0]         div_rem;

  pnp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // Combinational selection around the shared units.
  logic [1:0]              mac_row, mac_col;
  logic [3:0]              acc_idx;
  logic [4:0]              cnt_m1;
  logic [15:0]             coef;
  logic signed [31:0]      pos;
  logic signed [ClipW-1:0] w;
  logic [NumW-1:0]         a_sel, d_sel;
  logic [16:0]             b_sel;
  logic signed [ClipW:0]   cx_plus_w, w_minus_cy;
  logic [15:0]             min_x, min_y, max_x, max_y;
  logic                    vis_now;
  logic [QuoW-1:0]         q_round;
  logic [16:0]             sx_sum, sy_sum;
  logic [15:0]             sx, sy;
  logic signed [15:0]      depth;
  logic signed [16:0]      dx, dy;
  logic [RadW-1:0]         rad;
  logic [DistW-1:0]        dist_sq, rad2;
  logic                    hit;

  assign min_x = vp_min_q[15:0];
  assign min_y = vp_min_q[31:16];
  assign max_x = vp_max_q[15:0];
  assign max_y = vp_max_q[31:16];

  assign mac_row = cnt_q[3:2];
  assign mac_col = cnt_q[1:0];
  assign cnt_m1  = cnt_q - 5'd1;
  assign acc_idx = cnt_m1[3:0];
  assign coef    = mat_q[mac_row][16*mac_col +: 16];

  always_comb begin
    case (mac_col)
      2'd0:    pos = item_q.pos_x;
      2'd1:    pos = item_q.pos_y;
      2'd2:    pos = item_q.pos_z;
      default: pos = 32'sd0;
    endcase
  end

  assign w          = clip_q[3];
  assign cx_plus_w  = {clip_q[0][ClipW-1], clip_q[0]} + {w[ClipW-1], w};
  assign w_minus_cy = {w[ClipW-1], w} - {clip_q[1][ClipW-1], clip_q[1]};

  always_comb begin
    case (job_q)
      2'd0: begin
        a_sel = NumW'(cx_plus_w);
        b_sel = {1'b0, max_x - min_x};
        d_sel = NumW'({w, 1'b0});
      end
      2'd1: begin
        a_sel = NumW'(w_minus_cy);
        b_sel = {1'b0, max_y - min_y};
        d_sel = NumW'({w, 1'b0});
      end
      default: begin
        a_sel = clip_q[2][ClipW-1] ? NumW'(-clip_q[2]) : NumW'(clip_q[2]);
        b_sel = 17'(DepthOne);
        d_sel = NumW'(w);
      end
    endcase
  end

  assign div_num = {prod[36:0], 32'd0} + {21'd0, plo_q};
  assign div_den = d_sel;

  always_comb begin
    vis_now = (max_x > min_x) && (max_y > min_y) && (w > $signed(ClipW'(WEpsUnits)));
    for (int r = 0; r < 3; r++) begin
      if ((clip_q[r] < -w) || (clip_q[r] > w)) begin
        vis_now = 1'b0;
      end
    end
  end

  assign q_round = div_quo + QuoW'({div_rem, 1'b0} >= {1'b0, d_sel});

  assign sx_sum = {1'b0, min_x} + qres_q[0];
  assign sy_sum = {1'b0, min_y} + qres_q[1];
  assign sx     = sx_sum[16] ? 16'hFFFF : sx_sum[15:0];
  assign sy     = sy_sum[16] ? 16'hFFFF : sy_sum[15:0];
  assign depth  = clip_q[2][ClipW-1] ? -$signed(16'(qres_q[2])) : $signed(16'(qres_q[2]));

  assign dx      = $signed({1'b0, cursor_q[15:0]}) - $signed({1'b0, sx});
  assign dy      = $signed({1'b0, cursor_q[31:16]}) - $signed({1'b0, sy});
  assign rad     = {radius_q, {SCREEN_FRAC_BITS{1'b0}}};
  assign dist_sq = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign rad2    = DistW'(prod[2*RadW-1:0]);
  assign hit     = (dist_sq <= rad2) && (!found_q || (dist_sq < best_dist_q));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MAC: begin
        mul_a = {{(OpW-16){coef[15]}}, coef};
        mul_b = (mac_col == 2'd3) ? OpW'(65536) : {pos[31], pos};
      end
      S_MLO: begin
        mul_a = {1'b0, a_sel[31:0]};
        mul_b = {{(OpW-17){1'b0}}, b_sel};
      end
      S_MHI: begin
        mul_a = {{(OpW-(NumW-32)){1'b0}}, a_sel[NumW-1:32]};
        mul_b = {{(OpW-17){1'b0}}, b_sel};
      end
      S_SQX: begin
        mul_a = {{(OpW-17){dx[16]}}, dx};
        mul_b = {{(OpW-17){dx[16]}}, dx};
      end
      S_SQY: begin
        mul_a = {{(OpW-17){dy[16]}}, dy};
        mul_b = {{(OpW-17){dy[16]}}, dy};
      end
      S_SQR: begin
        mul_a = OpW'(rad);
        mul_b = OpW'(rad);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state_q == S_MWAIT);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= 64'd4096;
      mat_q[1] <= 64'd4096 << 16;
      mat_q[2] <= 64'd4096 << 32;
      mat_q[3] <= 64'd4096 << 48;
      vp_min_q <= '0;
      vp_max_q <= '0;
      cursor_q <= '0;
      radius_q <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRowX:   mat_q[0] <= cfg_data_i;
        RegRowY:   mat_q[1] <= cfg_data_i;
        RegRowZ:   mat_q[2] <= cfg_data_i;
        RegRowW:   mat_q[3] <= cfg_data_i;
        RegVpMin:  vp_min_q <= cfg_data_i[31:0];
        RegVpMax:  vp_max_q <= cfg_data_i[31:0];
        RegCursor: cursor_q <= cfg_data_i[31:0];
        RegRadius: radius_q <= cfg_data_i[7:0];
        default:   radius_q <= radius_q;
      endcase
    end
  end

  // Sequencer with its control and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      job_q       <= '0;
      vis_q       <= 1'b0;
      found_q     <= 1'b0;
      best_dist_q <= '0;
      best_obj_q  <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the hand-over state the register is refilled instead.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.frame_start) begin
              found_q     <= 1'b0;
              best_dist_q <= '0;
              best_obj_q  <= '0;
              best_x_q    <= '0;
              best_y_q    <= '0;
            end
            cnt_q   <= '0;
            job_q   <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          vis_q   <= vis_now;
          state_q <= vis_now ? S_MLO : S_DONE;
        end
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_MWAIT;
        S_MWAIT: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (job_q == 2'd2) begin
              state_q <= S_SQX;
            end else begin
              job_q   <= job_q + 2'd1;
              state_q <= S_MLO;
            end
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: state_q <= S_SQR;
        S_SQR: state_q <= S_CMP;
        S_CMP: begin
          if (hit) begin
            found_q     <= 1'b1;
            best_dist_q <= dist_sq;
            best_obj_q  <= ID_BITS'(item_q.object_id);
            best_x_q    <= sx;
            best_y_q    <= sy;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == S_MAC && cnt_q != 5'd0) begin
      if (acc_idx[1:0] == 2'd0) begin
        clip_q[acc_idx[3:2]] <= ClipW'(prod);
      end else begin
        clip_q[acc_idx[3:2]] <= clip_q[acc_idx[3:2]] + ClipW'(prod);
      end
    end
    if (state_q == S_MHI) begin
      plo_q <= prod[47:0];
    end
    if (state_q == S_DWAIT && div_done) begin
      qres_q[job_q] <= (job_q == 2'd2 && q_round > QuoW'(DepthOne)) ? QuoW'(DepthOne)
                                                                      : q_round;
    end
    if (state_q == S_SQY) begin
      dx2_q <= prod[32:0];
    end
    if (state_q == S_SQR) begin
      dy2_q <= prod[32:0];
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.visible     <= vis_q;
      out_q.screen_x    <= vis_q ? sx : 16'd0;
      out_q.screen_y    <= vis_q ? sy : 16'd0;
      out_q.depth       <= vis_q ? depth : 16'sd0;
      out_q.hover_valid <= found_q;
      out_q.hover_id    <= found_q ? 16'(best_obj_q) : 16'd0;
      out_q.hover_x     <= found_q ? best_x_q : 16'd0;
      out_q.hover_y     <= found_q ? best_y_q : 16'd0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT)
    else $error("divider finished outside its wait state");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |->
      out_data_o.screen_x == 16'd0 && out_data_o.depth == 16'sd0)
    else $error("rejected point carries screen data");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.depth <= 16'sd16384 && out_data_o.depth >= -16'sd16384)
    else $error("depth out of range");

  a_no_hover_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hover_valid |-> out_data_o.hover_id == 16'd0)
    else $error("hover id without a hit");

endmodule
`default_nettype wire
